/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro states one implication property on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* src/bmhpq_pkg.sv */
// Package for the binary max-heap priority queue: payload types, codes, constants.
// No dependencies.
`default_nettype none
package bmhpq_pkg;
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_EXTRACT  = 3'd1;
    localparam logic [2:0] CMD_INCREASE = 3'd2;
    localparam logic [2:0] CMD_DELETE   = 3'd3;
    localparam logic [2:0] CMD_ERASE    = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key_value;
        logic [7:0]         slot_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] top_key;
        logic signed [31:0] removed_key;
        logic [8:0]         entry_count;
        logic [2:0]         status;
    } rsp_t;

    // Operation handed from the front end to the engine.
    typedef enum logic [2:0] {
        OP_INSERT, OP_EXTRACT, OP_INCREASE, OP_DELETE, OP_ERASE, OP_CLEAR, OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] key;
        logic [7:0]         slot;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_WR, S_UP_RD, S_UP_WAIT, S_UP_CMP,
        S_INC_RD, S_INC_WAIT, S_INC_CHK,
        S_ER_RD, S_ER_WAIT, S_ER_CMP,
        S_TK_RD, S_TK_WAIT, S_TK_WR,
        S_DN_RDL, S_DN_RDR, S_DN_WL, S_DN_CMP,
        S_ROOT_RD, S_ROOT_WAIT, S_OUT
    } eng_state_t;
endpackage
`default_nettype wire

/* src/bmhpq_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module bmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* src/bmhpq_front.sv */
// Front end: accepts requests, classifies the command, and queues jobs (two entries).
// Depends on bmhpq_pkg.
`default_nettype none
module bmhpq_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bmhpq_pkg::req_t  in_req,
    output logic                  job_valid,
    input  wire logic             job_take,
    output bmhpq_pkg::job_t       job
);
    import bmhpq_pkg::*;

    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    job_t       cls;
    logic       push;
    logic       pop;

    always_comb
    begin
        cls.key  = in_req.key_value;
        cls.slot = in_req.slot_index;
        case (in_req.command)
            CMD_INSERT:   cls.op = OP_INSERT;
            CMD_EXTRACT:  cls.op = OP_EXTRACT;
            CMD_INCREASE: cls.op = OP_INCREASE;
            CMD_DELETE:   cls.op = OP_DELETE;
            CMD_ERASE:    cls.op = OP_ERASE;
            CMD_CLEAR:    cls.op = OP_CLEAR;
            default:      cls.op = OP_BAD;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end
endmodule
`default_nettype wire

/* src/bmhpq_engine.sv */
// Back end: carries out heap jobs one at a time over the key RAM and holds the result.
// Depends on bmhpq_pkg and bmhpq_ram.
`default_nettype none
module bmhpq_engine #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8,
    parameter int CW       = 9
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    output logic                 job_take,
    input  wire bmhpq_pkg::job_t job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bmhpq_pkg::rsp_t      out_rsp
);
    import bmhpq_pkg::*;

    eng_state_t state_reg, state_next;
    job_t       job_reg, job_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] best_reg, best_next;
    logic signed [31:0] cur_reg, cur_next;
    logic signed [31:0] bkey_reg, bkey_next;
    logic signed [31:0] rem_reg, rem_next;
    logic [2:0]    st_reg, st_next;
    logic          del_reg, del_next;
    rsp_t          rsp_reg, rsp_next;
    logic          ov_reg, ov_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
    logic signed [31:0] rdata;
    logic [CW-1:0] parent;
    logic [CW-1:0] last_idx;
    logic [CW:0]   lc;
    logic [CW:0]   rc;

    bmhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY), .AW(AW)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign parent   = (pos_reg - {{(CW-1){1'b0}}, 1'b1}) >> 1;
    assign last_idx = cnt_reg - {{(CW-1){1'b0}}, 1'b1};
    assign lc       = {pos_reg, 1'b1};
    assign rc       = {pos_reg, 1'b0} + {{(CW-1){1'b0}}, 2'd2};
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        pos_reg  <= pos_next;
        best_reg <= best_next;
        cur_reg  <= cur_next;
        bkey_reg <= bkey_next;
        rem_reg  <= rem_next;
        st_reg   <= st_next;
        del_reg  <= del_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        cur_next   = cur_reg;
        bkey_next  = bkey_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        del_next   = del_reg;
        rsp_next   = rsp_reg;
        ov_next    = ov_reg;
        job_take   = 1'b0;
        we         = 1'b0;
        addr       = pos_reg[AW-1:0];
        wdata      = cur_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid && !ov_reg)
                begin
                    job_take  = 1'b1;
                    job_next  = job;
                    rem_next  = KEY_MIN;
                    st_next   = ST_DONE;
                    del_next  = 1'b0;
                    pos_next  = {{(CW-AW){1'b0}}, job.slot};
                    cur_next  = job.key;
                    state_next = S_ROOT_RD;
                    case (job.op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = cnt_reg;
                                cnt_next   = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                                state_next = S_INS_WR;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_TK_RD;
                            end
                        end
                        OP_INCREASE:
                        begin
                            if ({{(CW-AW){1'b0}}, job.slot} >= cnt_reg)
                            begin
                                st_next = ST_IGNORED;
                            end
                            else
                            begin
                                state_next = S_INC_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if ({{(CW-AW){1'b0}}, job.slot} >= cnt_reg)
                            begin
                                st_next = ST_IGNORED;
                            end
                            else
                            begin
                                cur_next   = KEY_MAX;
                                del_next   = 1'b1;
                                state_next = S_INS_WR;
                            end
                        end
                        OP_ERASE:
                        begin
                            pos_next   = '0;
                            st_next    = ST_NOTFOUND;
                            state_next = S_ER_RD;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            st_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            // Write the moving key at pos, then sift it up, or go on down after a down move.
            S_INS_WR:
            begin
                we = 1'b1;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = del_reg ? S_TK_RD : S_ROOT_RD;
                end
                else
                begin
                    addr = parent[AW-1:0];
                    state_next = S_UP_WAIT;
                end
            end
            S_UP_WAIT:
            begin
                addr = parent[AW-1:0];
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (rdata < cur_reg)
                begin
                    we    = 1'b1;
                    wdata = rdata;
                    pos_next   = parent;
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = del_reg ? S_TK_RD : S_ROOT_RD;
                end
            end
            S_INC_RD:
            begin
                state_next = S_INC_WAIT;
            end
            S_INC_WAIT:
            begin
                state_next = S_INC_CHK;
            end
            S_INC_CHK:
            begin
                if (cur_reg < rdata)
                begin
                    st_next    = ST_IGNORED;
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            // Linear scan for the first slot equal to the key.
            S_ER_RD:
            begin
                if (pos_reg >= cnt_reg)
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    state_next = S_ER_WAIT;
                end
            end
            S_ER_WAIT:
            begin
                state_next = S_ER_CMP;
            end
            S_ER_CMP:
            begin
                if (rdata == cur_reg)
                begin
                    st_next    = ST_DONE;
                    cur_next   = KEY_MAX;
                    del_next   = 1'b1;
                    state_next = S_INS_WR;
                end
                else
                begin
                    pos_next   = pos_reg + {{(CW-1){1'b0}}, 1'b1};
                    state_next = S_ER_RD;
                end
            end
            // Take the root: read it, move the last key to the root, sift down.
            S_TK_RD:
            begin
                addr = '0;
                state_next = S_TK_WAIT;
            end
            S_TK_WAIT:
            begin
                addr = last_idx[AW-1:0];
                if (!del_reg)
                begin
                    rem_next = rdata;
                end
                cnt_next   = last_idx;
                state_next = S_TK_WR;
            end
            S_TK_WR:
            begin
                addr = '0;
                we   = 1'b1;
                wdata = rdata;
                cur_next = rdata;
                pos_next = '0;
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (lc >= {1'b0, cnt_reg})
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    addr = lc[AW-1:0];
                    state_next = S_DN_RDR;
                end
            end
            // The left child's key is on the read port now; the right one is fetched.
            S_DN_RDR:
            begin
                addr = rc[AW-1:0];
                if (rdata > cur_reg)
                begin
                    best_next = lc[CW-1:0];
                    bkey_next = rdata;
                end
                else
                begin
                    best_next = pos_reg;
                    bkey_next = cur_reg;
                end
                state_next = S_DN_WL;
            end
            S_DN_WL:
            begin
                addr = rc[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (rc < {1'b0, cnt_reg} && rdata > bkey_reg)
                begin
                    best_next = rc[CW-1:0];
                    bkey_next = rdata;
                end
                else
                begin
                    best_next = best_reg;
                    bkey_next = bkey_reg;
                end
                if (best_next == pos_reg)
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = bkey_next;
                    pos_next   = best_next;
                    state_next = S_INS_WR;
                    del_next   = 1'b0;
                    job_next.op = OP_EXTRACT;
                end
            end
            S_ROOT_RD:
            begin
                addr = '0;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                addr = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp_next.top_key     = (cnt_reg == '0) ? KEY_MIN : rdata;
                rsp_next.removed_key = rem_reg;
                rsp_next.entry_count = 9'(cnt_reg);
                rsp_next.status      = st_reg;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Down-move write: after S_DN_CMP writes the child into pos, the old key goes
        // into the child slot via S_INS_WR; the next sift-up step must not run, so a
        // down move returns to S_DN_RDL instead.
        if (state_reg == S_INS_WR && job_reg.op == OP_EXTRACT && !del_reg
            && state_next == S_UP_RD && (job_reg.op == OP_EXTRACT))
        begin
            state_next = S_DN_RDL;
        end
    end
endmodule
`default_nettype wire

/* src/binary_max_heap_priority_queue_core.sv */
// Binary max-heap priority queue of signed 32-bit keys, top level.
// Requests enter on in_valid/in_ready with a req_t payload; each request yields
// exactly one response on out_valid/out_ready with an rsp_t payload.
// A front end classifies requests into a two-entry job queue, so the block
// keeps taking requests while the heap engine works or a response waits.
// The engine runs one job at a time against a single-port key RAM with
// registered read, so each heap level needs separate read, wait and compare states.
// With an idle engine, a clear or ignored command steps through S_ROOT_RD,
// S_ROOT_WAIT and S_OUT before out_valid rises. A sift-up level steps
// through S_INS_WR, S_UP_RD, S_UP_WAIT and S_UP_CMP, a sift-down level
// through S_DN_RDL, S_DN_RDR, S_DN_WL, S_DN_CMP and S_INS_WR, and an erase
// through S_ER_RD, S_ER_WAIT and S_ER_CMP per slot scanned. Throughput is
// one request per job time; the sift loop over the RAM port sets it.
// Reset empties the heap (the count goes to zero) and drops queued requests;
// the RAM contents are not cleared since only slots below the count are read.
// When the receiver stalls, the response is held stable and the engine waits
// before starting its next job while the job queue fills.
`default_nettype none
module binary_max_heap_priority_queue_core #(
    parameter int CAPACITY = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bmhpq_pkg::req_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bmhpq_pkg::rsp_t      out_data
);
    import bmhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic job_valid;
    logic job_take;
    job_t job;

    bmhpq_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_req(in_data),
        .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    bmhpq_engine #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_take(job_take), .job(job),
        .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_data)
    );
endmodule
`default_nettype wire

/* src/bmhpq_checker.sv */
// Port-level checker for the heap queue top level, with its bind statement.
// Depends on bmhpq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bmhpq_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire bmhpq_pkg::rsp_t out_data
);
    import bmhpq_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMP(a_empty_top, clk, rst_n, out_valid && out_data.entry_count == 9'd0, out_data.top_key == KEY_MIN)
    `ASSERT_IMP(a_removed, clk, rst_n, out_valid && out_data.status != ST_DONE, out_data.removed_key == KEY_MIN)
    `ASSERT_IMP(a_status, clk, rst_n, out_valid, out_data.status <= ST_NOTFOUND)
endmodule
bind binary_max_heap_priority_queue_core bmhpq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for binary_max_heap_priority_queue_core: directed table, then random requests.
// Depends on bmhpq_pkg and the core RTL; keeps its own heap predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmhpq_pkg::*;

    localparam int DEPTH = 256;
    localparam int RANDOM_REQUESTS = 1330;
    localparam int STALL_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    always #6 clk = ~clk;

    binary_max_heap_priority_queue_core #(.CAPACITY(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // The predictor keeps its own copy of the heap array and count.
    logic signed [31:0] heap_keys [DEPTH];
    int unsigned heap_size;
    rsp_t pending_rsp [$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    function automatic void swap_keys(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void bubble_up(int unsigned pos);
        int unsigned up;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (!(heap_keys[up] < heap_keys[pos]))
                break;
            swap_keys(up, pos);
            pos = up;
        end
    endfunction

    function automatic void bubble_down(int unsigned pos);
        int unsigned best;
        forever
        begin
            best = pos;
            if (2*pos+1 < heap_size && heap_keys[2*pos+1] > heap_keys[best])
                best = 2*pos+1;
            if (2*pos+2 < heap_size && heap_keys[2*pos+2] > heap_keys[best])
                best = 2*pos+2;
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endfunction

    function automatic logic signed [31:0] pop_max();
        logic signed [31:0] top;
        top = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        if (heap_size > 0)
            bubble_down(0);
        return top;
    endfunction

    function automatic void drop_slot(int unsigned pos);
        heap_keys[pos] = KEY_MAX;
        bubble_up(pos);
        void'(pop_max());
    endfunction

    // Applies one request to the predicted heap and returns the response it should give.
    function automatic rsp_t heap_apply(req_t rq);
        rsp_t r;
        r.removed_key = KEY_MIN;
        r.status = ST_DONE;
        case (rq.command)
            CMD_INSERT:
                if (heap_size >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    heap_keys[heap_size] = rq.key_value;
                    heap_size++;
                    bubble_up(heap_size - 1);
                end
            CMD_EXTRACT:
                if (heap_size == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed_key = pop_max();
            CMD_INCREASE:
                if (rq.slot_index >= heap_size || rq.key_value < heap_keys[rq.slot_index])
                    r.status = ST_IGNORED;
                else
                begin
                    heap_keys[rq.slot_index] = rq.key_value;
                    bubble_up(rq.slot_index);
                end
            CMD_DELETE:
                if (rq.slot_index >= heap_size)
                    r.status = ST_IGNORED;
                else
                    drop_slot(rq.slot_index);
            CMD_ERASE:
            begin
                r.status = ST_NOTFOUND;
                for (int unsigned i = 0; i < heap_size; i++)
                begin
                    if (heap_keys[i] == rq.key_value)
                    begin
                        drop_slot(i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            CMD_CLEAR:
                heap_size = 0;
            default:
                r.status = ST_IGNORED;
        endcase
        r.top_key = heap_size > 0 ? heap_keys[0] : KEY_MIN;
        r.entry_count = heap_size[8:0];
        return r;
    endfunction

    // Directed table. A row with has_known set also carries the response read off
    // by hand; every row is still checked against the predictor as well.
    typedef struct {
        req_t rq;
        bit   has_known;
        rsp_t known;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic req_t mk(logic [2:0] c, logic signed [31:0] k, logic [7:0] s);
        req_t r;
        r.command = c;
        r.key_value = k;
        r.slot_index = s;
        return r;
    endfunction

    function automatic rsp_t rs(logic signed [31:0] t, logic signed [31:0] rm,
                                logic [8:0] n, logic [2:0] st);
        rsp_t r;
        r.top_key = t;
        r.removed_key = rm;
        r.entry_count = n;
        r.status = st;
        return r;
    endfunction

    task automatic add_row(req_t rq, bit known_flag = 1'b0, rsp_t known_rsp = '0);
        plan_row_t p;
        p.rq = rq;
        p.has_known = known_flag;
        p.known = known_rsp;
        plan.insert(plan.size(), p);
    endtask

    task automatic build_plan();
        // Empty heap: extract, delete, increase and erase all refuse.
        add_row(mk(CMD_EXTRACT, 0, 0), 1, rs(KEY_MIN, KEY_MIN, 0, ST_EMPTY));
        add_row(mk(CMD_DELETE, 0, 0), 1, rs(KEY_MIN, KEY_MIN, 0, ST_IGNORED));
        add_row(mk(CMD_INCREASE, 5, 0), 1, rs(KEY_MIN, KEY_MIN, 0, ST_IGNORED));
        add_row(mk(CMD_ERASE, 0, 0), 1, rs(KEY_MIN, KEY_MIN, 0, ST_NOTFOUND));
        add_row(mk(CMD_INSERT, KEY_MIN, 8'hFF), 1, rs(KEY_MIN, KEY_MIN, 1, ST_DONE));
        add_row(mk(CMD_INSERT, KEY_MAX, 0), 1, rs(KEY_MAX, KEY_MIN, 2, ST_DONE));
        add_row(mk(CMD_INSERT, 0, 0));
        add_row(mk(CMD_INSERT, -1, 0));
        add_row(mk(CMD_INSERT, 7, 0));
        // Increase with a larger or an equal key is accepted; an out-of-range slot is refused.
        add_row(mk(CMD_INCREASE, -2, 3));
        add_row(mk(CMD_INCREASE, 7, 1));
        add_row(mk(CMD_INCREASE, 100, 4));
        add_row(mk(CMD_INCREASE, 1, 8'hFF), 1, rs(KEY_MAX, KEY_MIN, 5, ST_IGNORED));
        add_row(mk(CMD_DELETE, 0, 2));
        add_row(mk(CMD_DELETE, 0, 8'hFF), 1, rs(KEY_MAX, KEY_MIN, 4, ST_IGNORED));
        add_row(mk(CMD_ERASE, 12345, 0));
        add_row(mk(CMD_ERASE, KEY_MIN, 0));
        add_row(mk(CMD_EXTRACT, 0, 0));
        add_row(mk(3'd6, 0, 0));
        add_row(mk(3'd7, -1, 8'hFF));
        add_row(mk(CMD_CLEAR, 0, 0), 1, rs(KEY_MIN, KEY_MIN, 0, ST_DONE));
    endtask

    // Presents one request and returns after its accepting edge. Valid stays high so
    // the next request can follow directly, unless an idle burst is drawn.
    task automatic send(req_t rq);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= rq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    // Random key: mostly a small pool so that erase and equal-key cases hit.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    // Random request. Fill phases lean on insert so the heap reaches full.
    function automatic req_t pick_request(bit filling);
        int unsigned roll;
        logic [2:0] c;
        logic [7:0] s;
        roll = $urandom_range(0, 99);
        if (filling)
            c = roll < 85 ? CMD_INSERT : 3'($urandom_range(1, 4));
        else if (roll < 35)
            c = CMD_INSERT;
        else if (roll < 55)
            c = CMD_EXTRACT;
        else if (roll < 70)
            c = CMD_INCREASE;
        else if (roll < 82)
            c = CMD_DELETE;
        else if (roll < 95)
            c = CMD_ERASE;
        else if (roll < 97)
            c = CMD_CLEAR;
        else
            c = 3'($urandom_range(6, 7));
        s = (heap_size > 0 && $urandom_range(0, 3) != 0) ?
            8'($urandom_range(0, heap_size - 1)) : 8'($urandom_range(0, 255));
        return mk(c, pick_key(), s);
    endfunction

    // Every accepted request gets its prediction at the accepting edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_rsp.insert(pending_rsp.size(), heap_apply(in_data));
    end

    // Response checker.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (out_data.top_key !== want.top_key)
                begin
                    $error("top_key expected %0d actual %0d", want.top_key, out_data.top_key);
                    errors++;
                end
                if (out_data.removed_key !== want.removed_key)
                begin
                    $error("removed_key expected %0d actual %0d",
                           want.removed_key, out_data.removed_key);
                    errors++;
                end
                if (out_data.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d",
                           want.entry_count, out_data.entry_count);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls in bursts until the quiet stretch at the end.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("binary_max_heap_priority_queue_core regression: fail");
            $finish;
        end
    end

    // Table rows with a hand-written response are compared to the predictor too,
    // so an error in either one is caught.
    initial
    begin
        rsp_t pred;
        heap_size = 0;
        build_plan();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].has_known)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending_rsp.size() == 0);
                send(plan[i].rq);
                @(negedge clk);
                in_valid <= 1'b0;
                pred = pending_rsp[$];
                if (pred != plan[i].known)
                begin
                    $error("table row %0d: expected %h predictor %h", i, plan[i].known, pred);
                    errors++;
                end
            end
            else
                send(plan[i].rq);
        end

        // Random phases: fill toward full, then mixed traffic; last part calm.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n >= RANDOM_REQUESTS - 150)
                calm = 1'b1;
            send(pick_request((n % 450) < 300));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending_rsp.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("binary_max_heap_priority_queue_core regression: pass");
        else
            $display("binary_max_heap_priority_queue_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
